// ----- rtl/csx_pkg.sv -----
`timescale 1ns / 1ps
// csx_pkg: shared widths and types for the CAN signal extract and scale block.
// No dependencies.
package csx_pkg;

  localparam int BYTE_BITS = 8;
  localparam int WORD_BITS = 64;
  localparam int LEN_W     = 7;
  localparam int SB_W      = 6;
  localparam int FACTOR_W  = 32;
  localparam int OFFSET_W  = 48;
  localparam int MAX_LEN   = 64;

  // Extracted field handed from the extractor to the scaling pipeline
  typedef struct packed {
    logic [WORD_BITS-1:0] raw;
    logic                 range_error;
  } csx_field_t;

endpackage

// ----- rtl/csx_extract.sv -----
`timescale 1ns / 1ps
// csx_extract: combinational bit-field extraction for Intel and Motorola layouts,
// sign extension and out-of-payload detection. Depends on csx_pkg.
module csx_extract #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic [csx_pkg::WORD_BITS-1:0] payload,
  input  logic [csx_pkg::SB_W-1:0]      start_bit,
  input  logic [csx_pkg::LEN_W-1:0]     bit_length,
  input  logic                          motorola_order,
  input  logic                          is_signed,
  output csx_pkg::csx_field_t           field
);
  import csx_pkg::*;

  localparam int PAYLOAD_BITS = BYTE_BITS * PAYLOAD_BYTES;
  localparam int NBYTES       = WORD_BITS / BYTE_BITS;

  logic [LEN_W-1:0]       len;
  logic [WORD_BITS-1:0]   pm;
  logic [WORD_BITS-1:0]   swapped;
  logic [WORD_BITS-1:0]   mask;
  logic [SB_W-1:0]        moto_lsb;
  logic [7:0]             moto_shift;
  logic [2*WORD_BITS-1:0] moto_wide;
  logic [WORD_BITS-1:0]   intel_bits;
  logic [WORD_BITS-1:0]   bits;
  logic [7:0]             end_pos;
  logic [SB_W-1:0]        sign_idx;
  logic                   sign_fill;

  // Clamp the length into 1..64
  always_comb begin
    if (bit_length == '0) begin
      len = LEN_W'(1);
    end else if (bit_length > LEN_W'(MAX_LEN)) begin
      len = LEN_W'(MAX_LEN);
    end else begin
      len = bit_length;
    end
  end

  // Zero the absent bytes and build the byte-swapped word for Motorola order
  always_comb begin
    for (int k = 0; k < NBYTES; k++) begin
      pm[k*BYTE_BITS +: BYTE_BITS] = (k < PAYLOAD_BYTES) ?
                                     payload[k*BYTE_BITS +: BYTE_BITS] : '0;
    end
    for (int k = 0; k < NBYTES; k++) begin
      swapped[k*BYTE_BITS +: BYTE_BITS] = pm[(NBYTES-1-k)*BYTE_BITS +: BYTE_BITS];
    end
  end

  assign mask = (len == LEN_W'(MAX_LEN)) ? '1 :
                ((WORD_BITS'(1) << len[SB_W-1:0]) - WORD_BITS'(1));

  // Intel: field LSB sits at start_bit
  assign intel_bits = pm >> start_bit;

  // Motorola: sawtooth numbering flips the bit within its byte; in the
  // byte-swapped word the field is contiguous and ends at 128 - lsb - len
  assign moto_lsb   = start_bit ^ SB_W'(BYTE_BITS - 1);
  assign moto_shift = 8'(2 * WORD_BITS) - {2'b00, moto_lsb} - {1'b0, len};
  assign moto_wide  = {swapped, {WORD_BITS{1'b0}}} >> moto_shift;

  assign bits = (motorola_order ? moto_wide[WORD_BITS-1:0] : intel_bits) & mask;

  // Any bit past the last present byte is a range error
  assign end_pos = (motorola_order ? {2'b00, moto_lsb} : {2'b00, start_bit}) +
                   {1'b0, len};

  // Sign extension over the full word
  assign sign_idx  = SB_W'(len - LEN_W'(1));
  assign sign_fill = is_signed && (len != LEN_W'(MAX_LEN)) && bits[sign_idx];

  assign field.raw         = sign_fill ? (bits | ~mask) : bits;
  assign field.range_error = (end_pos > 8'(PAYLOAD_BITS));

endmodule

// ----- rtl/can_signal_extract_scale.sv -----
`timescale 1ns / 1ps
// can_signal_extract_scale: top level, CAN signal unpack and fixed-point scale
// pipeline. Depends on csx_pkg and csx_extract.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | payload start_bit bit_length motorola_order
//          |                     | is_signed factor offset
//  out     | out_valid/out_ready | raw_value scaled_value was_clamped range_error
//
// One transaction per cycle sustained while out_ready is held high; each result
// passes the input register, the scaling stages and the output register.
// Depth is set by the 64 x 32 product, done as two 32 x 32 partial products in
// separate stages, then a sum stage and an offset add with saturation.
// Each stage advances when the next one is empty or moving, so bubbles close up
// while a result waits. Synchronous reset empties the pipeline.
module can_signal_extract_scale #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [csx_pkg::WORD_BITS-1:0] payload,
  input  logic        [csx_pkg::SB_W-1:0]      start_bit,
  input  logic        [csx_pkg::LEN_W-1:0]     bit_length,
  input  logic                                motorola_order,
  input  logic                                is_signed,
  input  logic signed [csx_pkg::FACTOR_W-1:0]  factor,
  input  logic signed [csx_pkg::OFFSET_W-1:0]  offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [csx_pkg::WORD_BITS-1:0] raw_value,
  output logic signed [csx_pkg::WORD_BITS-1:0] scaled_value,
  output logic                                was_clamped,
  output logic                                range_error
);
  import csx_pkg::*;

  localparam int NSTAGE = 7;
  localparam int HALF_W = WORD_BITS / 2;
  localparam int PROD_W = WORD_BITS + FACTOR_W;
  localparam int SUM_W  = PROD_W + 1;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;

  // stage 0: input register
  logic [WORD_BITS-1:0] pl0;
  logic [SB_W-1:0]      sb0;
  logic [LEN_W-1:0]     bl0;
  logic                 mo0;
  logic                 sg0;
  logic [FACTOR_W-1:0]  fac0;
  logic [OFFSET_W-1:0]  off0;
  // stage 1: extracted field
  logic [WORD_BITS-1:0] raw1;
  logic                 err1;
  logic                 sg1;
  logic [FACTOR_W-1:0]  fac1;
  logic [OFFSET_W-1:0]  off1;
  // stage 2: magnitudes
  logic [WORD_BITS-1:0] raw2;
  logic                 err2;
  logic [WORD_BITS-1:0] rmag2;
  logic [FACTOR_W-1:0]  fmag2;
  logic                 neg2;
  logic [OFFSET_W-1:0]  off2;
  // stage 3: low partial product
  logic [WORD_BITS-1:0] raw3;
  logic                 err3;
  logic [HALF_W-1:0]    rhi3;
  logic [FACTOR_W-1:0]  fmag3;
  logic [WORD_BITS-1:0] p0_3;
  logic                 neg3;
  logic [OFFSET_W-1:0]  off3;
  // stage 4: high partial product
  logic [WORD_BITS-1:0] raw4;
  logic                 err4;
  logic [WORD_BITS-1:0] p0_4;
  logic [WORD_BITS-1:0] p1_4;
  logic                 neg4;
  logic [OFFSET_W-1:0]  off4;
  // stage 5: full magnitude product
  logic [WORD_BITS-1:0] raw5;
  logic                 err5;
  logic [PROD_W-1:0]    prod5;
  logic                 neg5;
  logic [OFFSET_W-1:0]  off5;

  csx_field_t           field;
  logic                 rneg;
  logic [WORD_BITS-1:0] rmag_next;
  logic [FACTOR_W-1:0]  fmag_next;
  logic [SUM_W-1:0]     off_ext;
  logic [SUM_W-1:0]     prod_ext;
  logic [SUM_W-1:0]     sum;
  logic                 fits;

  // Stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pl0  <= payload;
      sb0  <= start_bit;
      bl0  <= bit_length;
      mo0  <= motorola_order;
      sg0  <= is_signed;
      fac0 <= factor;
      off0 <= offset;
    end
  end

  // Field extraction
  csx_extract #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_extract (
    .payload       (pl0),
    .start_bit     (sb0),
    .bit_length    (bl0),
    .motorola_order(mo0),
    .is_signed     (sg0),
    .field         (field)
  );

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      raw1 <= field.raw;
      err1 <= field.range_error;
      sg1  <= sg0;
      fac1 <= fac0;
      off1 <= off0;
    end
  end

  // Sign and magnitude of raw value and factor
  assign rneg      = sg1 && raw1[WORD_BITS-1];
  assign rmag_next = rneg ? (WORD_BITS'(0) - raw1) : raw1;
  assign fmag_next = fac1[FACTOR_W-1] ? (FACTOR_W'(0) - fac1) : fac1;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      raw2  <= raw1;
      err2  <= err1;
      rmag2 <= rmag_next;
      fmag2 <= fmag_next;
      neg2  <= rneg ^ fac1[FACTOR_W-1];
      off2  <= off1;
    end
  end

  // Low half times factor
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      raw3  <= raw2;
      err3  <= err2;
      rhi3  <= rmag2[WORD_BITS-1:HALF_W];
      fmag3 <= fmag2;
      p0_3  <= {{(WORD_BITS-HALF_W){1'b0}}, rmag2[HALF_W-1:0]} *
               {{(WORD_BITS-FACTOR_W){1'b0}}, fmag2};
      neg3  <= neg2;
      off3  <= off2;
    end
  end

  // High half times factor
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      raw4 <= raw3;
      err4 <= err3;
      p0_4 <= p0_3;
      p1_4 <= {{(WORD_BITS-HALF_W){1'b0}}, rhi3} *
              {{(WORD_BITS-FACTOR_W){1'b0}}, fmag3};
      neg4 <= neg3;
      off4 <= off3;
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      raw5  <= raw4;
      err5  <= err4;
      prod5 <= {{(PROD_W-WORD_BITS){1'b0}}, p0_4} +
               {p1_4[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
      neg5  <= neg4;
      off5  <= off4;
    end
  end

  // Offset add with product sign, then saturate to 64 bits
  assign off_ext  = {{(SUM_W-OFFSET_W){off5[OFFSET_W-1]}}, off5};
  assign prod_ext = {1'b0, prod5};
  assign sum      = neg5 ? (off_ext - prod_ext) : (off_ext + prod_ext);
  assign fits     = (sum[SUM_W-1:WORD_BITS-1] == {(SUM_W-WORD_BITS+1){sum[WORD_BITS-1]}});

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      raw_value   <= raw5;
      range_error <= err5;
      was_clamped <= !fits;
      if (fits) begin
        scaled_value <= sum[WORD_BITS-1:0];
      end else if (sum[SUM_W-1]) begin
        scaled_value <= {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
        scaled_value <= {1'b0, {(WORD_BITS-1){1'b1}}};
      end
    end
  end

`ifndef ASSERT_OFF
  // Any empty stage must let the input side move
  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    (vld != {NSTAGE{1'b1}}) |-> in_ready)
    else $error("input stalled with an empty pipeline stage");

  // A clamped result is one of the two saturation values
  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_clamped) |->
      (scaled_value == {1'b1, {(WORD_BITS-1){1'b0}}} ||
       scaled_value == {1'b0, {(WORD_BITS-1){1'b1}}}))
    else $error("clamped result is not a saturation value");

  // A result appears only when the stage before held a transaction
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[NSTAGE-2]))
    else $error("result appeared without a transaction behind it");
`endif

endmodule
